[sv/lruap_pkg.sv]
// Shared types and codes for the LRU store with age purge.
// No dependencies.
package lruap_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_W        = 64;
   localparam int VAL_W        = 32;
   localparam int TIME_W       = 32;
   localparam int MAXE_W       = 5;

   // command kinds
   localparam logic [2:0] K_INSERT = 3'd0;
   localparam logic [2:0] K_LOOKUP = 3'd1;
   localparam logic [2:0] K_EXISTS = 3'd2;
   localparam logic [2:0] K_REMOVE = 3'd3;
   localparam logic [2:0] K_PURGE  = 3'd4;
   localparam logic [2:0] K_POP    = 3'd5;

   // result status
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   // register indexes
   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_NOTIFY      = 1'b1;

   typedef struct packed {
      logic [2:0]        kind;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  new_value;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] max_age;
      logic              pop_key;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             is_freed;
      logic [KEY_W-1:0] out_key;
      logic [VAL_W-1:0] out_value;
      logic             hit;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic [TIME_W-1:0] stamp;
   } ent_type;

endpackage

[sv/lruap_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lruap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lru_cache_with_age_purge.sv]
// Top level of the LRU key-value store with age purge.
// Depends on lruap_pkg and lruap_ram.
//
// One command word is taken when start is high and busy is low; busy stays
// high until its final result. Entries live in one RAM kept in recency
// order (address 0 is the oldest, count-1 the newest), so no rank field is
// stored and removal closes the gap by moving the younger entries down one
// place. Every RAM step is a read followed by a write or a check, so the
// RAM port sets the pace of a key search, of moving entries behind a hit
// or a removal, and of a purge. Freed-entry reports come as words with
// is_freed set ahead of the final word, which has last set. Results are
// strobed on rsp_valid for one cycle each; the receiver cannot stall
// them. Configuration writes are always accepted (csr_ready is tied high)
// and are to be made only while the block is idle.
module lru_cache_with_age_purge #(
   parameter int CAPACITY = lruap_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lruap_pkg::req_type            req_word,
   output logic                          rsp_valid,
   output lruap_pkg::rsp_type            rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [lruap_pkg::MAXE_W-1:0]  csr_wdata
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CMW = (CW > lruap_pkg::MAXE_W) ? CW : lruap_pkg::MAXE_W;
   localparam int EW  = $bits(lruap_pkg::ent_type);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRD   = 4'd1;  // search: read
   localparam logic [3:0] S_SCMP  = 4'd2;  // search: compare
   localparam logic [3:0] S_MRD   = 4'd3;  // close gap: read
   localparam logic [3:0] S_MWR   = 4'd4;  // close gap: write one place down
   localparam logic [3:0] S_TAIL  = 4'd5;  // append refreshed entry or shrink
   localparam logic [3:0] S_EVCHK = 4'd6;  // eviction check after insert
   localparam logic [3:0] S_OLDCK = 4'd7;  // oldest entry read back
   localparam logic [3:0] S_PRD   = 4'd8;  // purge: read
   localparam logic [3:0] S_PCK   = 4'd9;  // purge: age check
   localparam logic [3:0] S_DONE  = 4'd10; // final word

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [lruap_pkg::MAXE_W-1:0] max_ff, max_in;
   logic          notify_ff, notify_in;

   lruap_pkg::req_type req_ff, req_in;
   lruap_pkg::ent_type ent_ff, ent_in;
   logic          tail_new_ff, tail_new_in;  // 1: write ent at end, 0: drop one
   logic          after_ev_ff, after_ev_in;  // check eviction after the tail

   lruap_pkg::rsp_type fin_ff, fin_in;
   lruap_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // RAM port
   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   lruap_pkg::ent_type wr_ent, rd_ent;
   logic [EW-1:0] rd_bits;

   logic          accept;
   logic          evict_due;
   logic [lruap_pkg::TIME_W-1:0] age;
   logic [CW-1:0] idx_dec, count_dec;

   lruap_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_ent    = lruap_pkg::ent_type'(rd_bits);
   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign idx_dec   = idx_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign age       = req_ff.now - rd_ent.stamp;
   assign evict_due = (max_ff != '0) && (CMW'(count_ff) >= CMW'(max_ff));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      max_in       = max_ff;
      notify_in    = notify_ff;
      req_in       = req_ff;
      ent_in       = ent_ff;
      tail_new_in  = tail_new_ff;
      after_ev_in  = after_ev_ff;
      fin_in       = fin_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_ent       = ent_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (csr_valid) begin
         case (csr_index)
            lruap_pkg::CSR_MAX_ENTRIES: max_in    = csr_wdata;
            lruap_pkg::CSR_NOTIFY:      notify_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_word;
               idx_in   = '0;
               kept_in  = '0;
               fin_in   = '0;
               fin_in.status = lruap_pkg::STAT_OK;
               fin_in.last   = 1'b1;
               case (req_word.kind)
                  lruap_pkg::K_INSERT, lruap_pkg::K_LOOKUP,
                  lruap_pkg::K_EXISTS, lruap_pkg::K_REMOVE: state_in = S_SRD;
                  lruap_pkg::K_PURGE: state_in = S_PRD;
                  lruap_pkg::K_POP: begin
                     if (count_ff == '0) begin
                        fin_in.status = lruap_pkg::STAT_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_OLDCK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_SRD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = S_SCMP;
            end else if (req_ff.kind == lruap_pkg::K_INSERT) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  fin_in.status = lruap_pkg::STAT_FULL;
                  state_in = S_DONE;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = count_ff[IW-1:0];
                  wr_ent.key   = req_ff.key;
                  wr_ent.value = req_ff.new_value;
                  wr_ent.stamp = req_ff.now;
                  count_in     = count_ff + 1'b1;
                  state_in     = S_EVCHK;
               end
            end else begin
               fin_in.status = lruap_pkg::STAT_NOTFOUND;
               state_in = S_DONE;
            end
         end

         S_SCMP: begin
            idx_in = idx_ff + 1'b1;
            if (rd_ent.key == req_ff.key) begin
               state_in = S_MRD;
               case (req_ff.kind)
                  lruap_pkg::K_INSERT: begin
                     ent_in.key   = req_ff.key;
                     ent_in.value = req_ff.new_value;
                     ent_in.stamp = req_ff.now;
                     tail_new_in  = 1'b1;
                     after_ev_in  = 1'b1;
                  end
                  lruap_pkg::K_LOOKUP, lruap_pkg::K_EXISTS: begin
                     ent_in.key   = rd_ent.key;
                     ent_in.value = rd_ent.value;
                     ent_in.stamp = req_ff.now;
                     fin_in.hit   = 1'b1;
                     fin_in.out_value = (req_ff.kind == lruap_pkg::K_LOOKUP) ?
                                        rd_ent.value : '0;
                     tail_new_in  = 1'b1;
                     after_ev_in  = 1'b0;
                  end
                  default: begin  // remove
                     if (notify_ff && (rd_ent.value != '0)) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in           = '0;
                        rsp_in.status    = lruap_pkg::STAT_OK;
                        rsp_in.is_freed  = 1'b1;
                        rsp_in.out_key   = rd_ent.key;
                        rsp_in.out_value = rd_ent.value;
                     end
                     tail_new_in = 1'b0;
                     after_ev_in = 1'b0;
                  end
               endcase
            end else begin
               state_in = S_SRD;
            end
         end

         S_MRD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = S_MWR;
            end else begin
               state_in = S_TAIL;
            end
         end

         S_MWR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_dec[IW-1:0];
            wr_ent   = rd_ent;
            idx_in   = idx_ff + 1'b1;
            state_in = S_MRD;
         end

         S_TAIL: begin
            if (tail_new_ff) begin
               wr_en   = 1'b1;
               wr_addr = count_dec[IW-1:0];
               wr_ent  = ent_ff;
            end else begin
               count_in = count_dec;
            end
            state_in = after_ev_ff ? S_EVCHK : S_DONE;
         end

         S_EVCHK: begin
            if (evict_due) begin
               rd_en    = 1'b1;
               state_in = S_OLDCK;
            end else begin
               state_in = S_DONE;
            end
         end

         S_OLDCK: begin
            if (req_ff.kind == lruap_pkg::K_POP) begin
               if (req_ff.pop_key) begin
                  fin_in.out_key = rd_ent.key;
               end else begin
                  fin_in.out_value = rd_ent.value;
               end
            end else if (notify_ff && (rd_ent.value != '0)) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.status    = lruap_pkg::STAT_OK;
               rsp_in.is_freed  = 1'b1;
               rsp_in.out_key   = rd_ent.key;
               rsp_in.out_value = rd_ent.value;
            end
            tail_new_in = 1'b0;
            after_ev_in = 1'b0;
            idx_in      = CW'(1);
            state_in    = S_MRD;
         end

         S_PRD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = S_PCK;
            end else begin
               count_in = kept_ff;
               state_in = S_DONE;
            end
         end

         S_PCK: begin
            if (age > req_ff.max_age) begin
               if (notify_ff && (rd_ent.value != '0)) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.status    = lruap_pkg::STAT_OK;
                  rsp_in.is_freed  = 1'b1;
                  rsp_in.out_key   = rd_ent.key;
                  rsp_in.out_value = rd_ent.value;
               end
            end else begin
               // kept never passes idx, so the slot was read already
               wr_en   = 1'b1;
               wr_addr = kept_ff[IW-1:0];
               wr_ent  = rd_ent;
               kept_in = kept_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_PRD;
         end

         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in       = fin_ff;
            state_in     = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_ff       <= lruap_pkg::MAXE_W'(16);
         notify_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         notify_ff    <= notify_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      kept_ff     <= kept_in;
      req_ff      <= req_in;
      ent_ff      <= ent_in;
      tail_new_ff <= tail_new_in;
      after_ev_ff <= after_ev_in;
      fin_ff      <= fin_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[sv/lruap_chk.sv]
// Port-level checks for the LRU store, bound to the top level.
// Depends on lruap_pkg and lru_cache_with_age_purge.
module lruap_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input lruap_pkg::rsp_type rsp_word
);

   // a taken command holds the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command not taken");

   // the final word ends the command
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |-> !busy) else $error("busy after final word");

   // freed reports come only while a command is in flight
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> busy) else $error("report outside command");

   // a freed report is never final and always carries ok status
   a_report_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_freed |->
         !rsp_word.last && !rsp_word.hit && (rsp_word.status == lruap_pkg::STAT_OK))
      else $error("malformed freed report");

endmodule

bind lru_cache_with_age_purge lruap_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

[tb/lru_cache_with_age_purge_tb.sv]
// Testbench for the LRU key-value store with age purge: directed and random
// commands, a scoreboard that predicts every result word. Depends on lruap_pkg.
`timescale 1ns / 1ps

// Scoreboard: own model of the store in recency order, plus expected words.
class lru_scoreboard;
   logic [lruap_pkg::KEY_W-1:0]  ent_key   [$];   // index 0 is the oldest
   logic [lruap_pkg::VAL_W-1:0]  ent_value [$];
   logic [lruap_pkg::TIME_W-1:0] ent_stamp [$];
   int unsigned                  limit_cfg;
   bit                           notify_cfg;
   lruap_pkg::rsp_type           pending [$];
   int                           errors;
   int                           words_seen;

   function new();
      limit_cfg  = 16;
      notify_cfg = 1;
      errors     = 0;
      words_seen = 0;
   endfunction

   function void push_word(logic [1:0] st, logic fr, logic [lruap_pkg::KEY_W-1:0] k,
                           logic [lruap_pkg::VAL_W-1:0] v, logic h, logic l);
      lruap_pkg::rsp_type w;
      w.status = st; w.is_freed = fr; w.out_key = k;
      w.out_value = v; w.hit = h; w.last = l;
      pending.push_back(w);
   endfunction

   function int find_entry(logic [lruap_pkg::KEY_W-1:0] k);
      foreach (ent_key[i])
         if (ent_key[i] == k) return i;
      return -1;
   endfunction

   function void drop_entry(int idx);
      if (notify_cfg && ent_value[idx] != 0)
         push_word(lruap_pkg::STAT_OK, 1'b1, ent_key[idx], ent_value[idx], 1'b0, 1'b0);
      ent_key.delete(idx); ent_value.delete(idx); ent_stamp.delete(idx);
   endfunction

   function void to_newest(int idx, logic [lruap_pkg::TIME_W-1:0] t);
      logic [lruap_pkg::KEY_W-1:0] k;
      logic [lruap_pkg::VAL_W-1:0] v;
      k = ent_key[idx]; v = ent_value[idx];
      ent_key.delete(idx); ent_value.delete(idx); ent_stamp.delete(idx);
      ent_key.push_back(k); ent_value.push_back(v); ent_stamp.push_back(t);
   endfunction

   // Note an accepted command word and queue its expected results.
   function void note_command(lruap_pkg::req_type r);
      int idx;
      idx = find_entry(r.key);
      case (r.kind)
         lruap_pkg::K_INSERT: begin
            if (idx >= 0) begin
               ent_value[idx] = r.new_value;
               to_newest(idx, r.now);
            end else if (ent_key.size() >= lruap_pkg::CAPACITY_DEF) begin
               push_word(lruap_pkg::STAT_FULL, 1'b0, '0, '0, 1'b0, 1'b1);
               return;
            end else begin
               ent_key.push_back(r.key); ent_value.push_back(r.new_value);
               ent_stamp.push_back(r.now);
            end
            if (limit_cfg > 0 && ent_key.size() >= limit_cfg) drop_entry(0);
            push_word(lruap_pkg::STAT_OK, 1'b0, '0, '0, 1'b0, 1'b1);
         end
         lruap_pkg::K_LOOKUP, lruap_pkg::K_EXISTS: begin
            if (idx < 0) push_word(lruap_pkg::STAT_NOTFOUND, 1'b0, '0, '0, 1'b0, 1'b1);
            else begin
               push_word(lruap_pkg::STAT_OK, 1'b0, '0,
                         (r.kind == lruap_pkg::K_LOOKUP) ? ent_value[idx] : '0,
                         1'b1, 1'b1);
               to_newest(idx, r.now);
            end
         end
         lruap_pkg::K_REMOVE: begin
            if (idx < 0) push_word(lruap_pkg::STAT_NOTFOUND, 1'b0, '0, '0, 1'b0, 1'b1);
            else begin
               drop_entry(idx);
               push_word(lruap_pkg::STAT_OK, 1'b0, '0, '0, 1'b0, 1'b1);
            end
         end
         lruap_pkg::K_PURGE: begin
            for (int i = 0; i < ent_key.size(); ) begin
               if (lruap_pkg::TIME_W'(r.now - ent_stamp[i]) > r.max_age) drop_entry(i);
               else i++;
            end
            push_word(lruap_pkg::STAT_OK, 1'b0, '0, '0, 1'b0, 1'b1);
         end
         lruap_pkg::K_POP: begin
            if (ent_key.size() == 0)
               push_word(lruap_pkg::STAT_EMPTY, 1'b0, '0, '0, 1'b0, 1'b1);
            else begin
               if (r.pop_key)
                  push_word(lruap_pkg::STAT_OK, 1'b0, ent_key[0], '0, 1'b0, 1'b1);
               else
                  push_word(lruap_pkg::STAT_OK, 1'b0, '0, ent_value[0], 1'b0, 1'b1);
               ent_key.delete(0); ent_value.delete(0); ent_stamp.delete(0);
            end
         end
         default: push_word(lruap_pkg::STAT_OK, 1'b0, '0, '0, 1'b0, 1'b1);
      endcase
   endfunction

   // Compare one result word with the oldest expectation.
   function void check_word(lruap_pkg::rsp_type got);
      lruap_pkg::rsp_type w;
      words_seen++;
      if (pending.size() == 0) begin
         $error("unexpected result word %p", got);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
         $error("status: expected %0d, got %0d", w.status, got.status); errors++;
      end
      if (got.is_freed !== w.is_freed) begin
         $error("is_freed: expected %0d, got %0d", w.is_freed, got.is_freed); errors++;
      end
      if (got.out_key !== w.out_key) begin
         $error("out_key: expected %h, got %h", w.out_key, got.out_key); errors++;
      end
      if (got.out_value !== w.out_value) begin
         $error("out_value: expected %h, got %h", w.out_value, got.out_value);
         errors++;
      end
      if (got.hit !== w.hit) begin
         $error("hit: expected %0d, got %0d", w.hit, got.hit); errors++;
      end
      if (got.last !== w.last) begin
         $error("last: expected %0d, got %0d", w.last, got.last); errors++;
      end
   endfunction
endclass

module lru_cache_with_age_purge_tb;
   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   lruap_pkg::req_type             req_word;
   logic                           rsp_valid;
   lruap_pkg::rsp_type             rsp_word;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_index;
   logic [lruap_pkg::MAXE_W-1:0]   csr_wdata;

   lru_scoreboard                  board;
   bit                             gaps_on;
   logic [lruap_pkg::TIME_W-1:0]   clock_secs;   // simulated wall time for commands
   logic [lruap_pkg::KEY_W-1:0]    key_pool [8]; // small pool so keys hit often
   int                             cmd_count;

   lru_cache_with_age_purge uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result words cannot be held off: check every strobed word at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_word(rsp_word);
   end

   // Drive one command word; hold start until the block takes it.
   // The block stays busy after a take, so stepping to a falling edge
   // before driving costs nothing.
   task automatic send_command(lruap_pkg::req_type r);
      if (gaps_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 8)) @(negedge clock);
      else
         @(negedge clock);
      req_word <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(r);
      cmd_count++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Register writes only once the block is idle and all words are back.
   // Leave a quiet stretch before the write as well.
   task automatic write_reg(logic idx, logic [lruap_pkg::MAXE_W-1:0] val);
      while (board.pending.size() != 0 || busy) @(negedge clock);
      repeat (4 * lruap_pkg::CAPACITY_DEF + 10) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == lruap_pkg::CSR_MAX_ENTRIES) board.limit_cfg = 32'(val);
      else board.notify_cfg = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic lruap_pkg::req_type make_cmd(logic [2:0] k,
                                        logic [lruap_pkg::KEY_W-1:0] key,
                                        logic [lruap_pkg::VAL_W-1:0] v,
                                        logic [lruap_pkg::TIME_W-1:0] t,
                                        logic [lruap_pkg::TIME_W-1:0] age, logic pk);
      lruap_pkg::req_type r;
      r.kind = k; r.key = key; r.new_value = v; r.now = t;
      r.max_age = age; r.pop_key = pk;
      return r;
   endfunction

   function automatic logic [lruap_pkg::KEY_W-1:0] rand_key();
      if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
      return {$urandom, $urandom};
   endfunction

   // Random command: mostly insert/lookup traffic on a small key pool.
   task automatic random_command();
      logic [2:0] k;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      k = lruap_pkg::K_INSERT;
      else if (pick < 55) k = lruap_pkg::K_LOOKUP;
      else if (pick < 65) k = lruap_pkg::K_EXISTS;
      else if (pick < 77) k = lruap_pkg::K_REMOVE;
      else if (pick < 85) k = lruap_pkg::K_PURGE;
      else if (pick < 96) k = lruap_pkg::K_POP;
      else                k = 3'($urandom_range(6, 7));
      clock_secs = clock_secs + $urandom_range(0, 20);
      send_command(make_cmd(k, rand_key(),
                            ($urandom_range(0, 4) == 0) ? '0 : $urandom,
                            ($urandom_range(0, 9) == 0) ? $urandom : clock_secs,
                            ($urandom_range(0, 4) == 0) ? $urandom
                                                        : $urandom_range(0, 60),
                            1'($urandom_range(0, 1))));
   endtask

   initial begin
      board      = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      csr_valid  = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      gaps_on    = 1'b1;
      cmd_count  = 0;
      clock_secs = 32'hFFFF_FFC0;   // wraps during the run
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty store, extremes, every kind, refresh and purge cases.
      send_command(make_cmd(lruap_pkg::K_POP, '0, '0, '0, '0, 1'b1));
      send_command(make_cmd(lruap_pkg::K_LOOKUP, '1, '0, '0, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_REMOVE, '1, '0, '0, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_INSERT, '0, '1, '1, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_INSERT, '1, '0, 32'd5, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_INSERT, 64'h5A5A, 32'h1234, 32'd7, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_INSERT, '0, 32'h55, 32'd9, '0, 1'b0)); // refresh
      send_command(make_cmd(lruap_pkg::K_EXISTS, '1, '0, 32'd10, '1, 1'b0));
      send_command(make_cmd(lruap_pkg::K_LOOKUP, 64'h5A5A, '0, 32'd11, '0, 1'b0));
      send_command(make_cmd(3'd6, '1, '1, '1, '1, 1'b1));
      send_command(make_cmd(3'd7, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_PURGE, '0, '0, 32'd11, '1, 1'b0));   // keeps all
      send_command(make_cmd(lruap_pkg::K_PURGE, '0, '0, 32'd12, 32'd1, 1'b0)); // age edge
      send_command(make_cmd(lruap_pkg::K_POP, '0, '0, '0, '0, 1'b1));
      send_command(make_cmd(lruap_pkg::K_REMOVE, 64'h5A5A, '0, '0, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_POP, '0, '0, '0, '0, 1'b0));

      // Max entries 1: the entry just written is evicted at once.
      write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd1);
      send_command(make_cmd(lruap_pkg::K_INSERT, 64'h77, 32'h99, '0, '0, 1'b0));
      write_reg(lruap_pkg::CSR_NOTIFY, 5'd0);
      send_command(make_cmd(lruap_pkg::K_INSERT, 64'h78, 32'h98, '0, '0, 1'b0));
      // No limit: fill beyond capacity to see store full, then purge all.
      write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd0);
      write_reg(lruap_pkg::CSR_NOTIFY, 5'd1);
      for (int i = 0; i < 17; i++)
         send_command(make_cmd(lruap_pkg::K_INSERT, lruap_pkg::KEY_W'(i + 100),
                               lruap_pkg::VAL_W'(i), 32'd50, '0, 1'b0));
      send_command(make_cmd(lruap_pkg::K_PURGE, '0, '0, 32'd60, '0, 1'b0));

      // Random phases over several register settings, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd16); end
            1: begin
               write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd31);
               write_reg(lruap_pkg::CSR_NOTIFY, 5'd0);
            end
            2: begin
               write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd4);
               write_reg(lruap_pkg::CSR_NOTIFY, 5'd1);
            end
            3: begin write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'd0); end
            default: begin
               write_reg(lruap_pkg::CSR_MAX_ENTRIES, 5'($urandom_range(2, 16)));
            end
         endcase
         if (phase == 4) gaps_on = 1'b0;   // final part runs flat out
         repeat (15) random_command();
      end

      while (board.pending.size() != 0) @(negedge clock);
      repeat (4 * lruap_pkg::CAPACITY_DEF + 10) @(negedge clock);
      $display("Covered %0d commands and %0d result words over several limits.",
               cmd_count, board.words_seen);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
